### hdl/chough_pkg.sv
package chough_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_VOTE  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Table selection codes for load items.
  localparam logic [1:0] TBL_A_EDGE   = 2'd0;
  localparam logic [1:0] TBL_B_CENTER = 2'd1;
  localparam logic [1:0] TBL_RADIUS   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_A_BINS = 2'd0;
  localparam logic [1:0] CFG_B_BINS = 2'd1;
  localparam logic [1:0] CFG_R_BINS = 2'd2;

  // One command transaction.
  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         table_select;
    logic [6:0]         table_index;
    logic signed [15:0] table_value;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [15:0]        weight;
    logic [3:0]         read_radius_bin;
    logic [5:0]         read_b_bin;
    logic [5:0]         read_a_bin;
  } cmd_item_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] read_value;
    logic [11:0] votes_cast;
    logic        saturated;
  } res_item_t;

endpackage

### hdl/chough_tables.sv
module chough_tables #(
  parameter int MAX_A_BINS = 64,
  parameter int MAX_B_BINS = 64,
  parameter int MAX_R_BINS = 16,
  parameter int EW = 7,
  parameter int BW = 6,
  parameter int RW = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [1:0]         wsel,
  input  logic [6:0]         widx,
  input  logic signed [15:0] wval,
  input  logic [EW-1:0]      edge_addr,
  input  logic [BW-1:0]      center_addr,
  input  logic [RW-1:0]      radius_addr,
  output logic signed [15:0] edge_data,
  output logic signed [15:0] center_data,
  output logic signed [15:0] radius_data
);
  import chough_pkg::*;

  logic signed [15:0] edge_mem   [MAX_A_BINS+1];
  logic signed [15:0] center_mem [MAX_B_BINS];
  logic signed [15:0] radius_mem [MAX_R_BINS];

  // Table writes, ignored beyond each table's depth.
  always_ff @(posedge clk) begin
    if (we && wsel == TBL_A_EDGE && 32'(widx) < MAX_A_BINS + 1) begin
      edge_mem[EW'(widx)] <= wval;
    end
    if (we && wsel == TBL_B_CENTER && 32'(widx) < MAX_B_BINS) begin
      center_mem[BW'(widx)] <= wval;
    end
    if (we && wsel == TBL_RADIUS && 32'(widx) < MAX_R_BINS) begin
      radius_mem[RW'(widx)] <= wval;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    edge_data   <= edge_mem[edge_addr];
    center_data <= center_mem[center_addr];
    radius_data <= radius_mem[radius_addr];
  end

endmodule

### hdl/chough_sqrt.sv
module chough_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  output logic        done,
  output logic [15:0] root
);
  import chough_pkg::*;

  logic [31:0] val;
  logic [18:0] rem;
  logic [4:0]  cnt;
  logic [18:0] rem_shift;
  logic [18:0] trial;

  // One result bit per cycle, restoring digit recurrence.
  assign rem_shift = {rem[16:0], val[31:30]};
  assign trial     = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val  <= value;
        rem  <= '0;
        root <= '0;
        cnt  <= 5'd16;
      end else if (cnt != '0) begin
        val <= {val[29:0], 2'b00};
        if (rem_shift >= trial) begin
          rem  <= rem_shift - trial;
          root <= {root[14:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/chough_acc.sv
module chough_acc #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  import chough_pkg::*;

  logic [31:0] mem [DEPTH];

  // Single-port accumulator store with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/circle_hough_accumulator_core.sv
// Circle Hough voting engine.
// Command channel: a transaction is taken when start is high and busy is low.
// Every command gives one result on result, marked by done for one cycle;
// the receiver takes it then and cannot stall it.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high; the user must make writes only while busy is low,
// which the block itself does not enforce. A load passes S_LOADW, a read
// S_RDW and S_RDCAP, and a clear zeroes all MAX_R_BINS*MAX_B_BINS*MAX_A_BINS
// entries, one entry a cycle. A vote steps S_RWAIT and S_RSQ per radius,
// S_BWAIT, S_DY, S_DY2, S_CMP and S_NEXT per (radius, b) pair and S_DONE to
// report; pairs on the circle add the bit-serial 16-step root, the edge search
// over all na edges and an S_AWAIT/S_AMOD update per accumulator write.
// One command is in flight at a time; the next is taken the cycle after done.
// Reset clears the accumulator in a pass over all MAX_R_BINS*MAX_B_BINS*MAX_A_BINS
// entries with busy high and no result; configuration writes are still taken.
// The bin tables are undefined after reset until loaded.
module circle_hough_accumulator_core #(
  parameter int MAX_A_BINS = 64,
  parameter int MAX_B_BINS = 64,
  parameter int MAX_R_BINS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  chough_pkg::cmd_item_t command,
  output logic                  done,
  output chough_pkg::res_item_t result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [6:0]            cfg_data
);
  import chough_pkg::*;

  localparam int AW   = (MAX_A_BINS > 1) ? $clog2(MAX_A_BINS) : 1;
  localparam int BW   = (MAX_B_BINS > 1) ? $clog2(MAX_B_BINS) : 1;
  localparam int RW   = (MAX_R_BINS > 1) ? $clog2(MAX_R_BINS) : 1;
  localparam int EW   = $clog2(MAX_A_BINS + 1);
  localparam int NBW  = $clog2(MAX_B_BINS + 1);
  localparam int NRW  = $clog2(MAX_R_BINS + 1);
  localparam int ACC_DEPTH = MAX_R_BINS * MAX_B_BINS * MAX_A_BINS;
  localparam int ACC_AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_CLEAR = 23'h000002,
    S_RDW   = 23'h000004,
    S_RDCAP = 23'h000008,
    S_RWAIT = 23'h000010,
    S_RSQ   = 23'h000020,
    S_BWAIT = 23'h000040,
    S_DY    = 23'h000080,
    S_DY2   = 23'h000100,
    S_CMP   = 23'h000200,
    S_SQRT  = 23'h000400,
    S_E0W   = 23'h000800,
    S_E0    = 23'h001000,
    S_ENW   = 23'h002000,
    S_EN    = 23'h004000,
    S_EKW   = 23'h008000,
    S_EK    = 23'h010000,
    S_SIDE  = 23'h020000,
    S_AWAIT = 23'h040000,
    S_AMOD  = 23'h080000,
    S_NEXT  = 23'h100000,
    S_LOADW = 23'h200000,
    S_DONE  = 23'h400000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0] a_bins;
  logic [6:0] b_bins;
  logic [4:0] r_bins;

  // Vote context.
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [15:0]        w;
  logic [EW-1:0]      na;
  logic [NBW-1:0]     nb;
  logic [NRW-1:0]     nr;
  logic [NRW-1:0]     ir;
  logic [NBW-1:0]     ib;
  logic [EW-1:0]      k;
  logic [30:0]        r2;
  logic signed [16:0] dy;
  logic [32:0]        dy2;
  logic signed [17:0] vp;
  logic signed [17:0] vm;
  logic               lo1, lo2, hi1, hi2, f1, f2;
  logic [AW-1:0]      bin1, bin2;
  logic               side;
  logic               h1, h2;

  // Accumulator access.
  logic [ACC_AW-1:0]  acc_addr;
  logic [ACC_AW-1:0]  clr_cnt;
  logic               clr_report;
  logic [ACC_AW-1:0]  mem_addr;
  logic               mem_we;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;
  logic [32:0]        sum;

  // Table ports.
  logic               tbl_we;
  logic signed [15:0] edge_data, center_data, radius_data;
  logic signed [17:0] edge_x;

  // Root unit.
  logic               sq_start;
  logic [31:0]        sq_value;
  logic               sq_done;
  logic [15:0]        sq_root;

  // Result registers.
  logic [31:0] res_value;
  logic [11:0] res_votes;
  logic        res_sat;

  logic [EW-1:0]  na_clamp;
  logic [NBW-1:0] nb_clamp;
  logic [NRW-1:0] nr_clamp;

  // Counts above the store sizes act as the sizes.
  assign na_clamp = (32'(a_bins) > MAX_A_BINS) ? EW'(MAX_A_BINS) : EW'(a_bins);
  assign nb_clamp = (32'(b_bins) > MAX_B_BINS) ? NBW'(MAX_B_BINS) : NBW'(b_bins);
  assign nr_clamp = (32'(r_bins) > MAX_R_BINS) ? NRW'(MAX_R_BINS) : NRW'(r_bins);

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = 1'b1;
  assign result    = '{read_value: res_value, votes_cast: res_votes, saturated: res_sat};

  assign tbl_we   = start && !busy && command.operation == OP_LOAD;
  assign edge_x   = 18'(edge_data);
  assign sq_start = (state == S_CMP) && !(dy2 > {2'b00, r2});
  assign sq_value = {1'b0, r2 - dy2[30:0]};
  assign h1       = lo1 && hi1 && f1;
  assign h2       = lo2 && hi2 && f2 && !(h1 && bin1 == bin2);
  assign sum      = {1'b0, mem_rdata} + 33'(w);

  // Accumulator port: sweep address while clearing.
  assign mem_addr  = (state == S_CLEAR) ? clr_cnt : acc_addr;
  assign mem_we    = (state == S_CLEAR) || (state == S_AMOD);
  assign mem_wdata = (state == S_CLEAR) ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);

  chough_tables #(
    .MAX_A_BINS(MAX_A_BINS), .MAX_B_BINS(MAX_B_BINS), .MAX_R_BINS(MAX_R_BINS),
    .EW(EW), .BW(BW), .RW(RW)
  ) u_tables (
    .clk(clk),
    .we(tbl_we),
    .wsel(command.table_select),
    .widx(command.table_index),
    .wval(command.table_value),
    .edge_addr(k),
    .center_addr(ib[BW-1:0]),
    .radius_addr(ir[RW-1:0]),
    .edge_data(edge_data),
    .center_data(center_data),
    .radius_data(radius_data)
  );

  chough_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .start(sq_start),
    .value(sq_value),
    .done(sq_done),
    .root(sq_root)
  );

  chough_acc #(.DEPTH(ACC_DEPTH), .AW(ACC_AW)) u_acc (
    .clk(clk),
    .we(mem_we),
    .addr(mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_bins <= 7'd64;
      b_bins <= 7'd64;
      r_bins <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_A_BINS: a_bins <= cfg_data;
        CFG_B_BINS: b_bins <= cfg_data;
        CFG_R_BINS: r_bins <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            res_value <= '0;
            res_votes <= '0;
            res_sat   <= 1'b0;
            px <= command.point_x;
            py <= command.point_y;
            w  <= command.weight;
            na <= na_clamp;
            nb <= nb_clamp;
            nr <= nr_clamp;
            ir <= '0;
            ib <= '0;
            case (command.operation)
              OP_CLEAR: begin
                clr_cnt    <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              OP_LOAD: state <= S_LOADW;
              OP_VOTE: begin
                if (na_clamp == '0 || nb_clamp == '0 || nr_clamp == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_RWAIT;
                end
              end
              default: begin
                if (32'(command.read_radius_bin) < MAX_R_BINS &&
                    32'(command.read_b_bin) < MAX_B_BINS &&
                    32'(command.read_a_bin) < MAX_A_BINS) begin
                  acc_addr <= ACC_AW'((32'(command.read_radius_bin) * MAX_B_BINS +
                              32'(command.read_b_bin)) * MAX_A_BINS +
                              32'(command.read_a_bin));
                  state <= S_RDW;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == ACC_DEPTH - 1) begin
            state <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_LOADW: state <= S_DONE;
        S_RDW:   state <= S_RDCAP;
        S_RDCAP: begin
          res_value <= mem_rdata;
          state     <= S_DONE;
        end
        S_RWAIT: state <= S_RSQ;
        S_RSQ: begin
          r2    <= 31'(radius_data * radius_data);
          state <= S_BWAIT;
        end
        S_BWAIT: state <= S_DY;
        S_DY: begin
          dy    <= 17'(17'(py) - 17'(center_data));
          state <= S_DY2;
        end
        S_DY2: begin
          dy2   <= 33'(dy * dy);
          state <= S_CMP;
        end
        S_CMP: state <= (dy2 > {2'b00, r2}) ? S_NEXT : S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            vp    <= 18'(px) + 18'(sq_root);
            vm    <= 18'(px) - 18'(sq_root);
            k     <= '0;
            state <= S_E0W;
          end
        end
        S_E0W: state <= S_E0;
        S_E0: begin
          lo1   <= (vp >= edge_x);
          lo2   <= (vm >= edge_x);
          k     <= na;
          state <= S_ENW;
        end
        S_ENW: state <= S_EN;
        S_EN: begin
          hi1   <= (vp < edge_x);
          hi2   <= (vm < edge_x);
          f1    <= 1'b0;
          f2    <= 1'b0;
          k     <= EW'(1);
          state <= S_EKW;
        end
        S_EKW: state <= S_EK;
        S_EK: begin
          if (!f1 && vp < edge_x) begin
            f1   <= 1'b1;
            bin1 <= AW'(k - 1'b1);
          end
          if (!f2 && vm < edge_x) begin
            f2   <= 1'b1;
            bin2 <= AW'(k - 1'b1);
          end
          if (k == na) begin
            side  <= 1'b0;
            state <= S_SIDE;
          end else begin
            k     <= k + 1'b1;
            state <= S_EKW;
          end
        end
        S_SIDE: begin
          if (!side) begin
            if (h1) begin
              acc_addr <= ACC_AW'((32'(ir) * MAX_B_BINS + 32'(ib)) * MAX_A_BINS +
                          32'(bin1));
              state <= S_AWAIT;
            end else begin
              side <= 1'b1;
            end
          end else if (h2) begin
            acc_addr <= ACC_AW'((32'(ir) * MAX_B_BINS + 32'(ib)) * MAX_A_BINS +
                        32'(bin2));
            state <= S_AWAIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_AWAIT: state <= S_AMOD;
        S_AMOD: begin
          res_votes <= res_votes + 12'd1;
          if (sum[32]) begin
            res_sat <= 1'b1;
          end
          if (!side) begin
            side  <= 1'b1;
            state <= S_SIDE;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (ib + 1'b1 != nb) begin
            ib    <= ib + 1'b1;
            state <= S_BWAIT;
          end else if (ir + 1'b1 != nr) begin
            ir    <= ir + 1'b1;
            ib    <= '0;
            state <= S_RWAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
